// ----- rtl/core/kvs_pkg.sv -----
// kvs_pkg: shared types and constants of the keyed value store
// operation and status codes, field widths, controller/datapath structs
`timescale 1ns / 1ps

package kvs_pkg;

    localparam int OP_W    = 3;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 5;

    localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
    localparam logic [OP_W-1:0] OP_ERASE       = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP_KEY  = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP_DATA = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic start;   // latch a new request word, restart the slot scan
        logic step;    // issue the next slot read, fold in the current compare
        logic finish;  // commit the table update and load the response register
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic done;    // outcome of the current request is settled
    } t_dp_flags;

endpackage

// ----- rtl/core/kvs_ifs.sv -----
// kvs_req_if / kvs_rsp_if: valid/ready channels of the keyed value store
// depends on kvs_pkg for the field widths
`timescale 1ns / 1ps

interface kvs_req_if;
    import kvs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] data;

    modport source (output valid, output operation, output key, output data, input ready);
    modport sink   (input valid, input operation, input key, input data, output ready);
endinterface

interface kvs_rsp_if;
    import kvs_pkg::*;

    logic               valid;
    logic               ready;
    logic               success;
    logic [STAT_W-1:0]  status;
    logic [ENTRY_W-1:0] entry_count;

    modport source (output valid, output success, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input success, input status, input entry_count,
                    output ready);
endinterface

// ----- rtl/core/kvs_ram.sv -----
// kvs_ram: generic single write port, single read port RAM with registered read
// no package dependency
`timescale 1ns / 1ps

module kvs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/kvs_ctrl.sv -----
// kvs_ctrl: request/response sequencing of the keyed value store
// depends on kvs_pkg for the command and flag structs
`timescale 1ns / 1ps

module kvs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  kvs_pkg::t_dp_flags  i_flags,
    output kvs_pkg::t_ctrl_cmd  o_cmd
);
    import kvs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state    r_state, n_state;
    logic      r_out_valid, n_out_valid;
    t_ctrl_cmd cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.start = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_flags.done) begin
                    cmd.step = 1'b1;
                end else if (!r_out_valid || i_out_ready) begin
                    // response register free this cycle
                    cmd.finish  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ----- rtl/core/kvs_dpath.sv -----
// kvs_dpath: slot memory, valid bits, entry count, slot scan and response register
// depends on kvs_pkg and kvs_ram
`timescale 1ns / 1ps

module kvs_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kvs_pkg::t_ctrl_cmd             i_cmd,
    output kvs_pkg::t_dp_flags             o_flags,
    input  logic [kvs_pkg::OP_W-1:0]       i_operation,
    input  logic [kvs_pkg::KEY_W-1:0]      i_key,
    input  logic [kvs_pkg::DATA_W-1:0]     i_data,
    output logic                           o_success,
    output logic [kvs_pkg::STAT_W-1:0]     o_status,
    output logic [kvs_pkg::ENTRY_W-1:0]    o_entry_count
);
    import kvs_pkg::*;

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int MEM_W = KEY_W + DATA_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    // request word
    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_data;

    // scan state
    logic [IW-1:0] r_idx;
    logic          r_pend;
    logic [IW-1:0] r_pidx;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;

    // table state
    logic [CAPACITY-1:0] r_valid, n_valid;
    logic [CW-1:0]       r_count, n_count;

    // response register
    logic               r_success;
    logic [STAT_W-1:0]  r_status;
    logic [ENTRY_W-1:0] r_entry;

    logic [MEM_W-1:0]  rd_word;
    logic [KEY_W-1:0]  rd_key;
    logic [DATA_W-1:0] rd_data;
    logic              slot_live;
    logic              hit;
    logic              last;
    logic              free_now;
    logic [IW-1:0]     free_idx;
    logic              immediate;
    logic              done;
    logic              mem_we;
    logic              res_success;
    logic [STAT_W-1:0] res_status;

    kvs_ram #(
        .WIDTH (MEM_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (free_idx),
        .i_wdata ({r_key, r_data}),
        .i_re    (i_cmd.step),
        .i_raddr (r_idx),
        .o_rdata (rd_word)
    );

    assign rd_key  = rd_word[MEM_W-1:DATA_W];
    assign rd_data = rd_word[DATA_W-1:0];

    // compare stage on the slot read in the previous step
    assign slot_live = r_pend && r_valid[r_pidx];
    assign hit       = slot_live && ((r_op == OP_LOOKUP_DATA) ? (rd_data == r_data)
                                                              : (rd_key == r_key));
    assign last      = r_pend && (r_pidx == LAST_IDX);
    assign free_now  = r_free_found || (r_pend && !r_valid[r_pidx]);
    assign free_idx  = r_free_found ? r_free_idx : r_pidx;
    assign immediate = !((r_op == OP_INSERT) || (r_op == OP_ERASE) ||
                         (r_op == OP_LOOKUP_KEY) || (r_op == OP_LOOKUP_DATA));
    assign done      = immediate || hit || last;

    always_comb begin
        n_valid     = r_valid;
        n_count     = r_count;
        res_success = 1'b0;
        res_status  = ST_NOT_FOUND;
        mem_we      = 1'b0;
        case (r_op)
            OP_INSERT: begin
                if (hit) begin
                    res_status = ST_DUPLICATE;
                end else if (free_now) begin
                    n_valid[free_idx] = 1'b1;
                    n_count           = r_count + 1'b1;
                    res_success       = 1'b1;
                    res_status        = ST_OK;
                    mem_we            = i_cmd.finish;
                end else begin
                    res_status = ST_FULL;
                end
            end
            OP_ERASE: begin
                if (hit) begin
                    n_valid[r_pidx] = 1'b0;
                    n_count         = r_count - 1'b1;
                    res_success     = 1'b1;
                    res_status      = ST_OK;
                end
            end
            OP_LOOKUP_KEY, OP_LOOKUP_DATA: begin
                if (hit) begin
                    res_success = 1'b1;
                    res_status  = ST_OK;
                end
            end
            OP_CLEAR: begin
                n_valid     = '0;
                n_count     = '0;
                res_success = 1'b1;
                res_status  = ST_OK;
            end
            default: begin
                res_status = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= i_operation;
            r_key  <= i_key;
            r_data <= i_data;
        end
        if (i_cmd.step) begin
            r_pidx <= r_idx;
        end
        if (i_cmd.step && !r_free_found) begin
            r_free_idx <= r_pidx;
        end
        if (i_cmd.finish) begin
            r_success <= res_success;
            r_status  <= res_status;
            r_entry   <= ENTRY_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_free_found <= 1'b0;
            r_valid      <= '0;
            r_count      <= '0;
        end else begin
            if (i_cmd.start) begin
                r_idx        <= '0;
                r_pend       <= 1'b0;
                r_free_found <= 1'b0;
            end else if (i_cmd.step) begin
                r_idx  <= r_idx + 1'b1;
                r_pend <= 1'b1;
                if (r_pend && !r_valid[r_pidx]) begin
                    r_free_found <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_valid <= n_valid;
                r_count <= n_count;
            end
        end
    end

    assign o_flags.done  = done;
    assign o_success     = r_success;
    assign o_status      = r_status;
    assign o_entry_count = r_entry;

endmodule

// ----- rtl/core/keyed_value_store_core.sv -----
// keyed_value_store_core: top level of the keyed value store
// depends on kvs_pkg, kvs_ifs, kvs_ctrl, kvs_dpath (which holds kvs_ram)
//
//   channel   dir   handshake        payload
//   i_req     in    valid / ready    operation[2:0], key[31:0], data[31:0]
//   o_rsp     out   valid / ready    success, status[1:0], entry_count[4:0]
//
// one request word at a time; the slots are scanned through the single read port
// of the slot memory, one slot per cycle, with each compare made on the registered read word.
// clear and unused codes finish without a scan; a hit in slot j ends the scan there
// (duplicate inserts included); a storing or full insert, a miss or any other scan
// runs on to the last slot.
// a new word is taken while the previous response still waits in the output
// register; a stalled response only holds the finished scan until it is taken.
// synchronous active-low reset empties the table at once; no clearing pass.
`timescale 1ns / 1ps

module keyed_value_store_core #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kvs_req_if.sink    i_req,
    kvs_rsp_if.source  o_rsp
);
    import kvs_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_flags flags;

    kvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    kvs_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_flags       (flags),
        .i_operation   (i_req.operation),
        .i_key         (i_req.key),
        .i_data        (i_req.data),
        .o_success     (o_rsp.success),
        .o_status      (o_rsp.status),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule
